// ===== rtl/b1i_pkg.sv =====
// ----------------------------------------------------------------------------
// b1i_pkg
// Widths, the syndrome column table and shared types for the B1I word
// deinterleaver and BCH(15,11) single-error corrector.
// ----------------------------------------------------------------------------
package b1i_pkg;

    localparam int WORD_W = 30;
    localparam int CW_W   = 15;
    localparam int DATA_W = 11;
    localparam int PAR_W  = 4;
    localparam int IDX_W  = 4;

    localparam logic [IDX_W-1:0] IDX_PLAIN = 4'd0;

    // x^p mod (x^4 + x + 1), entry p belongs to codeword bit p
    localparam logic [PAR_W-1:0] SYN_COL [CW_W] = '{
        4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h6, 4'hC, 4'hB,
        4'h5, 4'hA, 4'h7, 4'hE, 4'hF, 4'hD, 4'h9
    };

    typedef logic [CW_W-1:0] codeword_t;

    typedef struct packed {
        codeword_t codeword;
        logic      fixed;
    } lane_res_t;

    // remainder of the codeword over g(x), as an xor of the set bits' columns
    function automatic logic [PAR_W-1:0] b1i_syndrome(input codeword_t cw);
        logic [PAR_W-1:0] s;
        s = '0;
        for (int p = 0; p < CW_W; p++)
        begin
            if (cw[p])
            begin
                s = s ^ SYN_COL[p];
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/b1i_in_if.sv =====
// ----------------------------------------------------------------------------
// b1i_in_if
// Input channel: one received 30-bit navigation word and its word index.
// ----------------------------------------------------------------------------
interface b1i_in_if;
    import b1i_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] raw_word;
    logic [IDX_W-1:0]  word_index;

    modport source (output valid, output raw_word, output word_index, input ready);
    modport sink   (input valid, input raw_word, input word_index, output ready);
endinterface

// ===== rtl/b1i_out_if.sv =====
// ----------------------------------------------------------------------------
// b1i_out_if
// Output channel: decoded word and per-codeword correction flags.
// ----------------------------------------------------------------------------
interface b1i_out_if;
    import b1i_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] decoded_word;
    logic              fix_first;
    logic              fix_second;

    modport source (output valid, output decoded_word, output fix_first,
                    output fix_second, input ready);
    modport sink   (input valid, input decoded_word, input fix_first,
                    input fix_second, output ready);
endinterface

// ===== rtl/b1i_word_deinterleave_bch_correct.sv =====
// ----------------------------------------------------------------------------
// b1i_word_deinterleave_bch_correct
// B1I navigation word decoder: polarity fix, 2x15 deinterleave and two
// parallel BCH(15,11) single-error correction lanes merged into one result.
//
//   channel    dir   payload                                  handshake
//   word_ch    in    raw_word[30], word_index[4]              valid/ready
//   result_ch  out   decoded_word[30], fix_first, fix_second  valid/ready
//   cfg        in    cfg_wdata[1] (polarity_invert)           cfg_we
//
// one word per cycle while the output register is free or being read; a result
// appears in the cycle after its transfer in; latency is set by the single
// output register after the lane merge. The output register frees as it is
// read, so input is taken in the same cycle a waiting result is read, and
// input stalls only when that register stays full
// reset clears the valid flag and polarity_invert; no clearing pass
// ----------------------------------------------------------------------------
module b1i_word_deinterleave_bch_correct
    import b1i_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    b1i_in_if.sink          word_ch,
    b1i_out_if.source       result_ch
);

    logic              polarity_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              fix1_reg;
    logic              fix1_next;
    logic              fix2_reg;
    logic              fix2_next;

    logic              take;
    logic [WORD_W-1:0] pol_word;
    codeword_t         cw1;
    codeword_t         cw2;
    lane_res_t         res1;
    lane_res_t         res2;

    assign word_ch.ready = !valid_reg || result_ch.ready;
    assign take          = word_ch.valid && word_ch.ready;

    assign pol_word = polarity_reg ? ~word_ch.raw_word : word_ch.raw_word;

    // even received positions to the first codeword, odd to the second
    always_comb
    begin
        for (int j = 0; j < CW_W; j++)
        begin
            cw1[CW_W-1-j] = pol_word[WORD_W-1-2*j];
            cw2[CW_W-1-j] = pol_word[WORD_W-2-2*j];
        end
    end

    b1i_lane u_lane_first
    (
        .codeword (cw1),
        .result   (res1)
    );

    b1i_lane u_lane_second
    (
        .codeword (cw2),
        .result   (res2)
    );

    // merge: data fields first, then parity fields; plain words pass with only the polarity fix
    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        fix1_next  = fix1_reg;
        fix2_next  = fix2_reg;
        if (result_ch.ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
            if (word_ch.word_index == IDX_PLAIN)
            begin
                word_next = pol_word;
                fix1_next = 1'b0;
                fix2_next = 1'b0;
            end
            else
            begin
                word_next = {res1.codeword[CW_W-1:PAR_W], res2.codeword[CW_W-1:PAR_W],
                             res1.codeword[PAR_W-1:0], res2.codeword[PAR_W-1:0]};
                fix1_next = res1.fixed;
                fix2_next = res2.fixed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            polarity_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                polarity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        fix1_reg <= fix1_next;
        fix2_reg <= fix2_next;
    end

    assign result_ch.valid        = valid_reg;
    assign result_ch.decoded_word = word_reg;
    assign result_ch.fix_first    = fix1_reg;
    assign result_ch.fix_second   = fix2_reg;

`ifndef SYNTHESIS
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> result_ch.valid)
        else $error("transfer in did not produce a result");

    a_plain_no_fix: assert property (@(posedge clk) disable iff (!rst_n)
        take && (word_ch.word_index == IDX_PLAIN) |=>
        !result_ch.fix_first && !result_ch.fix_second)
        else $error("correction flagged on an uninterleaved word");

    a_plain_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        take && (word_ch.word_index == IDX_PLAIN) |=>
        result_ch.decoded_word == $past(pol_word))
        else $error("uninterleaved word altered");

    a_lanes_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (b1i_syndrome(res1.codeword) == '0) && (b1i_syndrome(res2.codeword) == '0))
        else $error("corrected codeword still has a nonzero syndrome");
`endif

endmodule

// ===== rtl/b1i_lane.sv =====
// ----------------------------------------------------------------------------
// b1i_lane
// One BCH(15,11) lane: syndrome over g(x) = x^4 + x + 1 and single-bit flip.
// ----------------------------------------------------------------------------
module b1i_lane
    import b1i_pkg::*;
(
    input  codeword_t codeword,
    output lane_res_t result
);

    logic [PAR_W-1:0] syn;
    codeword_t        flip;

    assign syn = b1i_syndrome(codeword);

    // every nonzero syndrome matches exactly one column
    always_comb
    begin
        for (int p = 0; p < CW_W; p++)
        begin
            flip[p] = (syn == SYN_COL[p]);
        end
    end

    assign result.codeword = codeword ^ flip;
    assign result.fixed    = (syn != '0);

endmodule

// ===== test/b1i_word_deinterleave_bch_correct_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b1i_word_deinterleave_bch_correct_test
// Drives navigation words with random idle and stall on both channels and
// checks every decoded word and correction flag against a bit-level decoder
// model kept here, with the polarity register changed between phases.
// ----------------------------------------------------------------------------
module b1i_word_deinterleave_bch_correct_test;
    import b1i_pkg::*;

    localparam logic [4:0] GEN_POLY  = 5'h13;
    localparam int         IDLE_PCT  = 28;
    localparam int         WDOG_MAX  = 2000;
    localparam int         RAND_WORDS = 2000;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              fix_first;
        logic              fix_second;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    b1i_in_if  word_ch();
    b1i_out_if result_ch();

    b1i_word_deinterleave_bch_correct dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .word_ch   (word_ch),
        .result_ch (result_ch)
    );

    decoded_t pending_words[$];
    logic     invert_model;
    logic     no_idle;
    int       mismatch_count;
    int       quiet_cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // remainder over g(x) = x^4 + x + 1, bit 14 is the x^14 term
    function automatic logic [3:0] poly_rem(input logic [CW_W-1:0] cw);
        logic [4:0] r;
        r = '0;
        for (int k = CW_W - 1; k >= 0; k--)
        begin
            r = {r[3:0], cw[k]};
            if (r[4])
            begin
                r = r ^ GEN_POLY;
            end
        end
        return r[3:0];
    endfunction

    function automatic logic [CW_W-1:0] fix_lane(input logic [CW_W-1:0] cw,
                                                 output logic hit);
        logic [3:0]      s;
        logic [4:0]      pw;
        logic [CW_W-1:0] res;
        hit = 1'b0;
        res = cw;
        s   = poly_rem(cw);
        pw  = 5'd1;
        if (s != 4'd0)
        begin
            for (int p = 0; p < CW_W; p++)
            begin
                if (!hit && pw[3:0] == s)
                begin
                    res = cw ^ (15'd1 << p);
                    hit = 1'b1;
                end
                pw = pw << 1;
                if (pw[4])
                begin
                    pw = pw ^ GEN_POLY;
                end
            end
        end
        return res;
    endfunction

    function automatic decoded_t decode_word(input logic [WORD_W-1:0] raw,
                                             input logic [IDX_W-1:0] idx,
                                             input logic inv);
        logic [WORD_W-1:0] w;
        logic [CW_W-1:0]   cw1;
        logic [CW_W-1:0]   cw2;
        decoded_t          d;
        w   = inv ? ~raw : raw;
        cw1 = '0;
        cw2 = '0;
        if (idx == IDX_PLAIN)
        begin
            d.word       = w;
            d.fix_first  = 1'b0;
            d.fix_second = 1'b0;
            return d;
        end
        // even received positions feed the first lane, first bit is bit 29
        for (int pos = 0; pos < WORD_W; pos++)
        begin
            if (pos % 2 == 0)
            begin
                cw1 = {cw1[CW_W-2:0], w[WORD_W-1-pos]};
            end
            else
            begin
                cw2 = {cw2[CW_W-2:0], w[WORD_W-1-pos]};
            end
        end
        cw1    = fix_lane(cw1, d.fix_first);
        cw2    = fix_lane(cw2, d.fix_second);
        d.word = {cw1[14:4], cw2[14:4], cw1[3:0], cw2[3:0]};
        return d;
    endfunction

    function automatic logic [CW_W-1:0] make_codeword(input logic [10:0] data);
        return {data, poly_rem({data, 4'b0000})};
    endfunction

    function automatic logic [WORD_W-1:0] interleave(input logic [CW_W-1:0] cw1,
                                                     input logic [CW_W-1:0] cw2);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < CW_W; i++)
        begin
            w[WORD_W-1-2*i] = cw1[CW_W-1-i];
            w[WORD_W-2-2*i] = cw2[CW_W-1-i];
        end
        return w;
    endfunction

    // called from the clock-aligned test flow; valid stays high after the transfer
    // until the next call or a drain lowers it
    task automatic send_word(input logic [WORD_W-1:0] raw, input logic [IDX_W-1:0] idx);
        if (!no_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                word_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        word_ch.valid      <= 1'b1;
        word_ch.raw_word   <= raw;
        word_ch.word_index <= idx;
        @(posedge clk);
        while (!word_ch.ready)
        begin
            @(posedge clk);
        end
        pending_words.push_back(decode_word(raw, idx, invert_model));
    endtask

    task automatic wait_drained();
        word_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic set_polarity(input logic v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        invert_model  = v;
    endtask

    // random codeword pair, optionally with bit errors in each lane
    function automatic logic [WORD_W-1:0] coded_word(input int errs1, input int errs2);
        logic [CW_W-1:0] cw1;
        logic [CW_W-1:0] cw2;
        cw1 = make_codeword($urandom_range(2047));
        cw2 = make_codeword($urandom_range(2047));
        for (int i = 0; i < errs1; i++)
        begin
            cw1 = cw1 ^ (15'd1 << $urandom_range(CW_W - 1));
        end
        for (int i = 0; i < errs2; i++)
        begin
            cw2 = cw2 ^ (15'd1 << $urandom_range(CW_W - 1));
        end
        return interleave(cw1, cw2);
    endfunction

    task automatic test_plain_words();
        send_word('0, IDX_PLAIN);
        send_word({WORD_W{1'b1}}, IDX_PLAIN);
        send_word(30'h2AAA_5555, IDX_PLAIN);
    endtask

    task automatic test_clean_codewords();
        send_word('0, 4'd1);
        send_word({WORD_W{1'b1}}, 4'd1);
        send_word(coded_word(0, 0), 4'd9);
        send_word(coded_word(0, 0), 4'd15);
    endtask

    task automatic test_single_errors();
        logic [CW_W-1:0] cw;
        cw = make_codeword(11'h5A3);
        send_word(interleave(cw ^ 15'h0001, cw), 4'd2);
        send_word(interleave(cw, cw ^ 15'h4000), 4'd10);
        send_word(interleave(cw ^ 15'h0100, cw ^ 15'h0010), 4'd5);
        send_word(coded_word(1, 1), 4'd12);
    endtask

    task automatic test_multi_errors();
        logic [CW_W-1:0] cw;
        cw = make_codeword(11'h0F0);
        send_word(interleave(cw ^ 15'h0003, cw), 4'd4);
        send_word(interleave(cw, cw ^ 15'h4001), 4'd11);
        send_word(coded_word(3, 2), 4'd7);
    endtask

    task automatic test_polarity();
        set_polarity(1'b1);
        send_word('0, IDX_PLAIN);
        send_word({WORD_W{1'b1}}, IDX_PLAIN);
        send_word(~coded_word(0, 0), 4'd3);
        send_word(~coded_word(1, 0), 4'd14);
        send_word('0, 4'd8);
        set_polarity(1'b0);
        send_word(coded_word(0, 1), 4'd6);
    endtask

    task automatic test_random_traffic();
        logic [WORD_W-1:0] w;
        logic [IDX_W-1:0]  idx;
        int                kind;
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (n % 250 == 0)
            begin
                set_polarity(n % 500 == 0 ? 1'b1 : 1'($urandom_range(1)));
            end
            else if (n % 333 == 0)
            begin
                // hold off until the pipe is empty
                wait_drained();
            end
            no_idle = (n >= 800 && n < 1100);
            kind    = $urandom_range(99);
            if (kind < 30)
            begin
                w = coded_word(0, 0);
            end
            else if (kind < 70)
            begin
                w = coded_word($urandom_range(1), $urandom_range(1));
            end
            else if (kind < 88)
            begin
                w = coded_word($urandom_range(3), $urandom_range(3));
            end
            else
            begin
                w = WORD_W'($urandom);
            end
            if (invert_model && kind < 88)
            begin
                w = ~w;
            end
            idx = ($urandom_range(99) < 15) ? IDX_PLAIN : IDX_W'($urandom_range(1, 15));
            send_word(w, idx);
        end
        no_idle = 1'b0;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        decoded_t want;
        result_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none got %h %b %b", $time,
                         result_ch.decoded_word, result_ch.fix_first, result_ch.fix_second);
                mismatch_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (result_ch.decoded_word !== want.word)
                begin
                    $display("%0t decoded_word: expected %h got %h", $time,
                             want.word, result_ch.decoded_word);
                    mismatch_count++;
                end
                if (result_ch.fix_first !== want.fix_first)
                begin
                    $display("%0t fix_first: expected %b got %b", $time,
                             want.fix_first, result_ch.fix_first);
                    mismatch_count++;
                end
                if (result_ch.fix_second !== want.fix_second)
                begin
                    $display("%0t fix_second: expected %b got %b", $time,
                             want.fix_second, result_ch.fix_second);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (word_ch.valid && word_ch.ready)
            || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WDOG_MAX)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        word_ch.valid        = 1'b0;
        word_ch.raw_word     = '0;
        word_ch.word_index   = '0;
        result_ch.ready      = 1'b0;
        invert_model         = 1'b0;
        no_idle              = 1'b0;
        mismatch_count       = 0;
        quiet_cycles         = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_words();
        test_clean_codewords();
        test_single_errors();
        test_multi_errors();
        test_polarity();
        test_random_traffic();

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
